FILE: rtl/core/pem_pkg.sv
`timescale 1ns / 1ps

package pem_pkg;

  // channel pairs and field widths
  localparam int unsigned Pairs   = 4;
  localparam int unsigned PairW   = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned PScaleW = 24;
  localparam int unsigned EScaleW = 32;
  localparam int unsigned ActW    = 48;
  localparam int unsigned AppW    = 47;
  localparam int unsigned AEnW    = 64;
  localparam int unsigned UEnW    = 63;
  localparam int unsigned MulW    = 48;
  localparam int unsigned CntW    = 6;

  // configuration register indexes
  localparam logic CfgPowerScale  = 1'b0;
  localparam logic CfgEnergyScale = 1'b1;

  // reset values of the scale registers
  localparam logic [PScaleW-1:0] PowerScaleRst  = 24'd65536;
  localparam logic [EScaleW-1:0] EnergyScaleRst = 32'd1193046;

  // operand selection of the shared serial multiplier
  typedef logic [1:0] pem_sel_t;
  localparam pem_sel_t SelDiff  = 2'd0;
  localparam pem_sel_t SelAct   = 2'd1;
  localparam pem_sel_t SelReact = 2'd2;
  localparam pem_sel_t SelApp   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic     cap;
    logic     prod;
    logic     mag;
    logic     sum;
    logic     prep;
    logic     mul_start;
    pem_sel_t sel;
    logic     sqrt_start;
    logic     q_load;
    logic     en_upd;
    logic     out_load;
  } pem_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic win_end;
    logic mul_done;
    logic sqrt_done;
    logic out_free;
  } pem_sts_t;

endpackage

FILE: rtl/core/pem_if.sv
`timescale 1ns / 1ps

// sample request channel
interface pem_in_if;
  logic                                valid;
  logic                                ready;
  logic [pem_pkg::PairW-1:0]           pair_index;
  logic signed [pem_pkg::SampleW-1:0]  voltage_sample;
  logic signed [pem_pkg::SampleW-1:0]  current_sample;
  logic                                window_end;

  modport source (output valid, pair_index, voltage_sample, current_sample, window_end,
                  input ready);
  modport sink (input valid, pair_index, voltage_sample, current_sample, window_end,
                output ready);
endinterface

// result request channel
interface pem_out_if;
  logic                             valid;
  logic                             ready;
  logic [pem_pkg::PairW-1:0]        out_pair;
  logic signed [pem_pkg::ActW-1:0]  active_power;
  logic [pem_pkg::AppW-1:0]         apparent_power;
  logic [pem_pkg::AppW-1:0]         reactive_power;
  logic signed [pem_pkg::AEnW-1:0]  active_energy;
  logic [pem_pkg::UEnW-1:0]         reactive_energy;
  logic [pem_pkg::UEnW-1:0]         apparent_energy;

  modport source (output valid, out_pair, active_power, apparent_power, reactive_power,
                  active_energy, reactive_energy, apparent_energy, input ready);
  modport sink (input valid, out_pair, active_power, apparent_power, reactive_power,
                active_energy, reactive_energy, apparent_energy, output ready);
endinterface

FILE: rtl/core/pem_mul.sv
`timescale 1ns / 1ps

module pem_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pem_pkg::MulW-1:0]      a_i,
  input  logic [pem_pkg::MulW-1:0]      b_i,
  output logic                          done_o,
  output logic [2*pem_pkg::MulW-1:0]    p_o
);

  localparam int unsigned W = pem_pkg::MulW;

  logic [W-1:0]          a_q;
  logic [2*W-1:0]        p_q, p_d;
  logic [pem_pkg::CntW-1:0] cnt_q;
  logic                  busy_q, done_q;
  logic [W:0]            part;

  // one multiplier bit a step, shift-add from the low end
  always_comb begin
    part = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d  = {part, p_q[W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= pem_pkg::CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == pem_pkg::CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: rtl/core/pem_sqrt.sv
`timescale 1ns / 1ps

module pem_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2*pem_pkg::MulW-1:0]    rad_i,
  output logic                          done_o,
  output logic [pem_pkg::MulW-1:0]      root_o
);

  localparam int unsigned W = pem_pkg::MulW;

  logic [2*W-1:0]        rad_q;
  logic [W+1:0]          rem_q;
  logic [W-1:0]          root_q;
  logic [pem_pkg::CntW-1:0] cnt_q;
  logic                  busy_q, done_q;
  logic [W+3:0]          r2, trial, diff;
  logic                  take;

  // restoring root, two radicand bits a step
  always_comb begin
    r2    = {rem_q, rad_q[2*W-1:2*W-2]};
    trial = {2'b00, root_q, 2'b01};
    take  = (r2 >= trial);
    diff  = r2 - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= pem_pkg::CntW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == pem_pkg::CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*W-3:0], 2'b00};
      rem_q  <= take ? diff[W+1:0] : r2[W+1:0];
      root_q <= {root_q[W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/pem_dp.sv
`timescale 1ns / 1ps

module pem_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [pem_pkg::EScaleW-1:0]         cfg_data_i,
  input  logic [pem_pkg::PairW-1:0]           pair_index_i,
  input  logic signed [pem_pkg::SampleW-1:0]  voltage_sample_i,
  input  logic signed [pem_pkg::SampleW-1:0]  current_sample_i,
  input  logic                                window_end_i,
  input  pem_pkg::pem_cmd_t                   cmd_i,
  output pem_pkg::pem_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [pem_pkg::PairW-1:0]           out_pair_o,
  output logic signed [pem_pkg::ActW-1:0]     active_power_o,
  output logic [pem_pkg::AppW-1:0]            apparent_power_o,
  output logic [pem_pkg::AppW-1:0]            reactive_power_o,
  output logic signed [pem_pkg::AEnW-1:0]     active_energy_o,
  output logic [pem_pkg::UEnW-1:0]            reactive_energy_o,
  output logic [pem_pkg::UEnW-1:0]            apparent_energy_o
);

  localparam int unsigned W = pem_pkg::MulW;

  localparam logic signed [48:0] Max47 = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] Min47 = -49'sh0_8000_0000_0000;

  // scale registers
  logic [pem_pkg::PScaleW-1:0] ps_q;
  logic [pem_pkg::EScaleW-1:0] es_q;

  // captured sample and product pipeline
  logic [pem_pkg::PairW-1:0]          pair_q;
  logic signed [pem_pkg::SampleW-1:0] v_q, c_q;
  logic                               we_q;
  logic signed [31:0]                 prod_q;
  logic [38:0]                        imag_q;
  logic                               neg_q;

  // window values
  logic signed [pem_pkg::ActW-1:0] act_q;
  logic [pem_pkg::AppW-1:0]        app_q, q_q;
  logic [W-1:0]                    pmag_q, d_q, e_q;
  logic                            act_neg_q;

  // per pair state
  logic signed [pem_pkg::ActW-1:0] act_sum_q [pem_pkg::Pairs];
  logic [pem_pkg::AppW-1:0]        app_sum_q [pem_pkg::Pairs];
  logic signed [pem_pkg::AEnW-1:0] act_en_q  [pem_pkg::Pairs];
  logic [pem_pkg::UEnW-1:0]        rea_en_q  [pem_pkg::Pairs];
  logic [pem_pkg::UEnW-1:0]        app_en_q  [pem_pkg::Pairs];

  logic out_valid_q;

  // shared units
  logic [W-1:0]   mul_a, mul_b, root;
  logic [2*W-1:0] mul_p;
  logic           mul_done, sqrt_done;

  pem_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pem_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (mul_p),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // multiplier operands
  always_comb begin
    unique case (cmd_i.sel)
      pem_pkg::SelDiff:  begin mul_a = d_q;             mul_b = e_q; end
      pem_pkg::SelAct:   begin mul_a = pmag_q;          mul_b = W'(es_q); end
      pem_pkg::SelReact: begin mul_a = {1'b0, q_q};     mul_b = W'(es_q); end
      default:           begin mul_a = {1'b0, app_q};   mul_b = W'(es_q); end
    endcase
  end

  // instant power magnitude, ceiling for negative products
  logic [30:0] absp;
  logic [54:0] mag;
  logic [54:0] mag_rnd;
  always_comb begin
    absp    = prod_q[31] ? 31'(-prod_q) : prod_q[30:0];
    mag     = 55'(absp) * 55'(ps_q);
    mag_rnd = prod_q[31] ? mag + 55'(16'hFFFF) : mag;
  end

  // saturating window sums
  logic signed [48:0] simag, nact;
  logic [47:0]        napp;
  logic signed [pem_pkg::ActW-1:0] act_new;
  logic [pem_pkg::AppW-1:0]        app_new;
  always_comb begin
    simag = neg_q ? -$signed({10'b0, imag_q}) : $signed({10'b0, imag_q});
    nact  = $signed({act_sum_q[pair_q][47], act_sum_q[pair_q]}) + simag;
    napp  = {1'b0, app_sum_q[pair_q]} + 48'(imag_q);
    if (nact > Max47)      act_new = Max47[47:0];
    else if (nact < Min47) act_new = Min47[47:0];
    else                   act_new = nact[47:0];
    app_new = napp[47] ? {pem_pkg::AppW{1'b1}} : napp[46:0];
  end

  // energy increments and saturating sums
  logic [47:0] de_floor;
  logic [48:0] de_ceil, de_act;
  logic signed [64:0] ta;
  logic [63:0] tr, tp;
  logic signed [pem_pkg::AEnW-1:0] act_en_new;
  logic [pem_pkg::UEnW-1:0] rea_en_new, app_en_new;
  always_comb begin
    de_floor = mul_p[79:32];
    de_ceil  = {1'b0, de_floor} + 49'(|mul_p[31:0]);
    de_act   = act_neg_q ? de_ceil : {1'b0, de_floor};
    if (act_neg_q) ta = $signed({act_en_q[pair_q][63], act_en_q[pair_q]}) - $signed(65'(de_act));
    else           ta = $signed({act_en_q[pair_q][63], act_en_q[pair_q]}) + $signed(65'(de_act));
    if (ta[64] != ta[63]) act_en_new = act_neg_q ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else                  act_en_new = ta[63:0];
    tr = {1'b0, rea_en_q[pair_q]} + 64'(de_floor);
    tp = {1'b0, app_en_q[pair_q]} + 64'(de_floor);
    rea_en_new = tr[63] ? {pem_pkg::UEnW{1'b1}} : tr[62:0];
    app_en_new = tp[63] ? {pem_pkg::UEnW{1'b1}} : tp[62:0];
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= pem_pkg::PowerScaleRst;
      es_q <= pem_pkg::EnergyScaleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pem_pkg::CfgPowerScale:  ps_q <= cfg_data_i[pem_pkg::PScaleW-1:0];
        default:                 es_q <= cfg_data_i;
      endcase
    end
  end

  // sample pipeline and window working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      pair_q <= pair_index_i;
      v_q    <= voltage_sample_i;
      c_q    <= current_sample_i;
      we_q   <= window_end_i;
    end
    if (cmd_i.prod) prod_q <= v_q * c_q;
    if (cmd_i.mag) begin
      imag_q <= mag_rnd[54:16];
      neg_q  <= prod_q[31];
    end
    if (cmd_i.sum) begin
      act_q <= act_new;
      app_q <= app_new;
    end
    if (cmd_i.prep) begin
      act_neg_q <= act_q[47];
      pmag_q    <= act_q[47] ? 48'(-act_q) : act_q;
      d_q       <= ({1'b0, app_q} >= (act_q[47] ? 48'(-act_q) : act_q))
                   ? {1'b0, app_q} - (act_q[47] ? 48'(-act_q) : act_q)
                   : (act_q[47] ? 48'(-act_q) : act_q) - {1'b0, app_q};
      e_q       <= {1'b0, app_q} + (act_q[47] ? 48'(-act_q) : act_q);
    end
    if (cmd_i.q_load) q_q <= root[47] ? {pem_pkg::AppW{1'b1}} : root[46:0];
    if (cmd_i.out_load) begin
      out_pair_o        <= pair_q;
      active_power_o    <= act_q;
      apparent_power_o  <= app_q;
      reactive_power_o  <= q_q;
      active_energy_o   <= act_en_q[pair_q];
      reactive_energy_o <= rea_en_q[pair_q];
      apparent_energy_o <= app_en_q[pair_q];
    end
  end

  // per pair sums and energies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pem_pkg::Pairs; k++) begin
        act_sum_q[k] <= '0;
        app_sum_q[k] <= '0;
        act_en_q[k]  <= '0;
        rea_en_q[k]  <= '0;
        app_en_q[k]  <= '0;
      end
    end else begin
      if (cmd_i.sum) begin
        act_sum_q[pair_q] <= act_new;
        app_sum_q[pair_q] <= app_new;
      end
      if (cmd_i.en_upd) begin
        case (cmd_i.sel)
          pem_pkg::SelAct:   act_en_q[pair_q] <= act_en_new;
          pem_pkg::SelReact: rea_en_q[pair_q] <= rea_en_new;
          pem_pkg::SelApp:   app_en_q[pair_q] <= app_en_new;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        act_sum_q[pair_q] <= '0;
        app_sum_q[pair_q] <= '0;
      end
    end
  end

  // output holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sts_o.win_end   = we_q;
  assign sts_o.mul_done  = mul_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/core/pem_ctrl.sv
`timescale 1ns / 1ps

module pem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pem_pkg::pem_sts_t sts_i,
  output pem_pkg::pem_cmd_t cmd_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StProd   = 4'd1;
  localparam logic [3:0] StMag    = 4'd2;
  localparam logic [3:0] StSum    = 4'd3;
  localparam logic [3:0] StPrep   = 4'd4;
  localparam logic [3:0] StMulD   = 4'd5;
  localparam logic [3:0] StWaitD  = 4'd6;
  localparam logic [3:0] StWaitSq = 4'd7;
  localparam logic [3:0] StMulA   = 4'd8;
  localparam logic [3:0] StWaitA  = 4'd9;
  localparam logic [3:0] StMulR   = 4'd10;
  localparam logic [3:0] StWaitR  = 4'd11;
  localparam logic [3:0] StMulP   = 4'd12;
  localparam logic [3:0] StWaitP  = 4'd13;
  localparam logic [3:0] StOut    = 4'd14;

  logic [3:0] state_q, state_d;

  // sequencing and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = pem_pkg::SelDiff;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = StProd;
        end
      end
      StProd: begin
        cmd_o.prod = 1'b1;
        state_d    = StMag;
      end
      StMag: begin
        cmd_o.mag = 1'b1;
        state_d   = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = sts_i.win_end ? StPrep : StIdle;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StMulD;
      end
      StMulD: begin
        cmd_o.mul_start = 1'b1;
        state_d         = StWaitD;
      end
      StWaitD: begin
        if (sts_i.mul_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = StWaitSq;
        end
      end
      StWaitSq: begin
        if (sts_i.sqrt_done) begin
          cmd_o.q_load = 1'b1;
          state_d      = StMulA;
        end
      end
      StMulA: begin
        cmd_o.sel       = pem_pkg::SelAct;
        cmd_o.mul_start = 1'b1;
        state_d         = StWaitA;
      end
      StWaitA: begin
        cmd_o.sel = pem_pkg::SelAct;
        if (sts_i.mul_done) begin
          cmd_o.en_upd = 1'b1;
          state_d      = StMulR;
        end
      end
      StMulR: begin
        cmd_o.sel       = pem_pkg::SelReact;
        cmd_o.mul_start = 1'b1;
        state_d         = StWaitR;
      end
      StWaitR: begin
        cmd_o.sel = pem_pkg::SelReact;
        if (sts_i.mul_done) begin
          cmd_o.en_upd = 1'b1;
          state_d      = StMulP;
        end
      end
      StMulP: begin
        cmd_o.sel       = pem_pkg::SelApp;
        cmd_o.mul_start = 1'b1;
        state_d         = StWaitP;
      end
      StWaitP: begin
        cmd_o.sel = pem_pkg::SelApp;
        if (sts_i.mul_done) begin
          cmd_o.en_upd = 1'b1;
          state_d      = StOut;
        end
      end
      StOut: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/power_energy_meter.sv
`timescale 1ns / 1ps

// Power and energy meter for four voltage/current channel pairs.
// in_i carries one sample request: pair index, voltage and current sample
// and a window-end flag. out_o carries one result request per window end:
// active, apparent and reactive power and the three running energies.
// Configuration: cfg_we_i with cfg_idx_i (0 power scale Q8.16, 1 energy
// scale Q0.32) and cfg_data_i; write only while the block is idle.
// After a sample is accepted, in_i.ready stays low through the product,
// scaling and accumulate stages of the sequencer.
// For a window-end sample it stays low until the result is loaded: those
// three stages, a prep step, one serial 48-bit multiply for |S^2-P^2|, a
// 48-step square root, three serial energy multiplies and the output load,
// which waits for a free output slot; the multiplies all share one
// shift-add multiplier.
// Reset clears all window sums and energies and restores the scale
// registers; no clearing pass is needed.
// The result sits in an output register; if out_o.ready is low the next
// sample is still taken, and only a further window end waits for the slot.
module power_energy_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pem_pkg::EScaleW-1:0]   cfg_data_i,
  pem_in_if.sink                        in_i,
  pem_out_if.source                     out_o
);

  pem_pkg::pem_cmd_t cmd;
  pem_pkg::pem_sts_t sts;

  // controller
  pem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  pem_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .pair_index_i      (in_i.pair_index),
    .voltage_sample_i  (in_i.voltage_sample),
    .current_sample_i  (in_i.current_sample),
    .window_end_i      (in_i.window_end),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_pair_o        (out_o.out_pair),
    .active_power_o    (out_o.active_power),
    .apparent_power_o  (out_o.apparent_power),
    .reactive_power_o  (out_o.reactive_power),
    .active_energy_o   (out_o.active_energy),
    .reactive_energy_o (out_o.reactive_energy),
    .apparent_energy_o (out_o.apparent_energy)
  );

  // an accepted sample keeps the input closed for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted on consecutive cycles");

  // a new result is only loaded while the sequencer holds the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result loaded while input open");

endmodule

FILE: verif/power_energy_meter_test.sv
`timescale 1ns / 1ps

module power_energy_meter_test;

  localparam int unsigned CycleLimit = 5000000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    logic [pem_pkg::PairW-1:0]        pair;
    logic signed [pem_pkg::ActW-1:0]  act;
    logic [pem_pkg::AppW-1:0]         app;
    logic [pem_pkg::AppW-1:0]         react;
    logic signed [pem_pkg::AEnW-1:0]  act_en;
    logic [pem_pkg::UEnW-1:0]         react_en;
    logic [pem_pkg::UEnW-1:0]         app_en;
  } meter_result_t;

  // window sums, energies and the expected results of closed windows
  class meter_scoreboard;
    logic [pem_pkg::PScaleW-1:0]     power_scale;
    logic [pem_pkg::EScaleW-1:0]     energy_scale;
    longint                          act_sum [pem_pkg::Pairs];
    longint                          app_sum [pem_pkg::Pairs];
    logic signed [pem_pkg::AEnW-1:0] act_en [pem_pkg::Pairs];
    logic [pem_pkg::UEnW-1:0]        react_en [pem_pkg::Pairs];
    logic [pem_pkg::UEnW-1:0]        app_en [pem_pkg::Pairs];
    meter_result_t                   pending [$];
    int                              errors;

    function new();
      power_scale  = pem_pkg::PowerScaleRst;
      energy_scale = pem_pkg::EnergyScaleRst;
      errors       = 0;
      for (int k = 0; k < pem_pkg::Pairs; k++) begin
        act_sum[k]  = 0;
        app_sum[k]  = 0;
        act_en[k]   = '0;
        react_en[k] = '0;
        app_en[k]   = '0;
      end
    endfunction

    // floor (or ceiling for debits) of x * energy_scale / 2^32
    function logic [127:0] energy_step(logic [127:0] x, bit up);
      logic [127:0] m;
      m = x * 128'(energy_scale);
      if (up) m = m + 128'hFFFF_FFFF;
      return m >> 32;
    endfunction

    // accumulate one accepted sample request, close the window on its end flag
    function void note_sample(logic [pem_pkg::PairW-1:0] p,
                              logic signed [pem_pkg::SampleW-1:0] v,
                              logic signed [pem_pkg::SampleW-1:0] c, logic wend);
      longint              prod;
      logic [63:0]         mag;
      logic [63:0]         inst;
      longint              na;
      longint              act;
      logic [127:0]        pm, ap, d, e, n, q, t, de;
      logic signed [127:0] s;
      meter_result_t       r;
      prod = longint'(v) * longint'(c);
      mag  = 64'(prod < 0 ? -prod : prod) * 64'(power_scale);
      inst = (prod < 0) ? (mag + 64'd65535) >> 16 : mag >> 16;
      na = act_sum[p] + ((prod < 0) ? -longint'(inst) : longint'(inst));
      if (na > 64'sh7FFF_FFFF_FFFF) na = 64'sh7FFF_FFFF_FFFF;
      if (na < -64'sh8000_0000_0000) na = -64'sh8000_0000_0000;
      act_sum[p] = na;
      app_sum[p] = app_sum[p] + longint'(inst);
      if (app_sum[p] > 64'sh7FFF_FFFF_FFFF) app_sum[p] = 64'sh7FFF_FFFF_FFFF;
      if (!wend) return;

      act = act_sum[p];
      pm  = (act < 0) ? 128'(-act) : 128'(act);
      ap  = 128'(app_sum[p]);
      d   = (ap >= pm) ? ap - pm : pm - ap;
      e   = ap + pm;
      n   = d * e;
      // bitwise floor square root
      q = '0;
      for (int b = 48; b >= 0; b--) begin
        t = q | (128'd1 << b);
        if (t * t <= n) q = t;
      end
      if (q > 128'h7FFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF;

      // saturating energy updates
      de = energy_step(pm, act < 0);
      s  = act_en[p];
      s  = (act < 0) ? s - signed'(de) : s + signed'(de);
      if (s > 128'sh7FFF_FFFF_FFFF_FFFF) s = 128'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -128'sh8000_0000_0000_0000) s = -128'sh8000_0000_0000_0000;
      act_en[p] = s[63:0];
      t = 128'(react_en[p]) + energy_step(q, 1'b0);
      react_en[p] = (t > 128'h7FFF_FFFF_FFFF_FFFF) ? 63'h7FFF_FFFF_FFFF_FFFF : t[62:0];
      t = 128'(app_en[p]) + energy_step(ap, 1'b0);
      app_en[p] = (t > 128'h7FFF_FFFF_FFFF_FFFF) ? 63'h7FFF_FFFF_FFFF_FFFF : t[62:0];

      r.pair     = p;
      r.act      = act[pem_pkg::ActW-1:0];
      r.app      = ap[pem_pkg::AppW-1:0];
      r.react    = q[pem_pkg::AppW-1:0];
      r.act_en   = act_en[p];
      r.react_en = react_en[p];
      r.app_en   = app_en[p];
      pending.push_back(r);
      act_sum[p] = 0;
      app_sum[p] = 0;
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result request with the oldest expectation
    function void check_result(meter_result_t got);
      meter_result_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result for pair %0d", $realtime, got.pair);
        errors++;
        return;
      end
      w = pending.pop_front();
      cmp("out_pair", 64'(w.pair), 64'(got.pair));
      cmp("active_power", 64'(w.act), 64'(got.act));
      cmp("apparent_power", 64'(w.app), 64'(got.app));
      cmp("reactive_power", 64'(w.react), 64'(got.react));
      cmp("active_energy", w.act_en, got.act_en);
      cmp("reactive_energy", 64'(w.react_en), 64'(got.react_en));
      cmp("apparent_energy", 64'(w.app_en), 64'(got.app_en));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_idx_i = pem_pkg::CfgPowerScale;
  logic [pem_pkg::EScaleW-1:0]  cfg_data_i = '0;
  bit                           quiet = 1'b0;
  int unsigned                  cycles = 0;
  meter_scoreboard              meter;

  pem_in_if  in_ch ();
  pem_out_if out_ch ();

  power_energy_meter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, check on every accepted request
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 22);
  end
  always @(posedge clk_i) begin
    meter_result_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.pair     = out_ch.out_pair;
      got.act      = out_ch.active_power;
      got.app      = out_ch.apparent_power;
      got.react    = out_ch.reactive_power;
      got.act_en   = out_ch.active_energy;
      got.react_en = out_ch.reactive_energy;
      got.app_en   = out_ch.apparent_energy;
      meter.check_result(got);
    end
  end

  // one sample request with random idle cycles ahead of it
  task automatic send_sample(logic [pem_pkg::PairW-1:0] p, logic [pem_pkg::SampleW-1:0] v,
                             logic [pem_pkg::SampleW-1:0] c, logic wend);
    while (!quiet && $urandom_range(99) < 22) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          = 1'b1;
    in_ch.pair_index     = p;
    in_ch.voltage_sample = v;
    in_ch.current_sample = c;
    in_ch.window_end     = wend;
    do @(posedge clk_i); while (!in_ch.ready);
    meter.note_sample(p, v, c, wend);
    @(negedge clk_i);
  endtask

  // drain all results, let the block go idle, then write both scales
  task automatic set_scales(logic [pem_pkg::PScaleW-1:0] ps, logic [pem_pkg::EScaleW-1:0] es);
    in_ch.valid = 1'b0;
    while (meter.pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = pem_pkg::CfgPowerScale;
    cfg_data_i = pem_pkg::EScaleW'(ps);
    @(negedge clk_i);
    cfg_idx_i  = pem_pkg::CfgEnergyScale;
    cfg_data_i = es;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    meter.power_scale  = ps;
    meter.energy_scale = es;
  endtask

  function automatic logic [pem_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return pem_pkg::SampleW'($urandom);
    endcase
  endfunction

  // mostly short windows on random pairs
  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      quiet = (k >= n / 3) && (k < n / 2);
      send_sample(pem_pkg::PairW'($urandom), pick_sample(), pick_sample(),
                  $urandom_range(5) == 0);
    end
    quiet = 1'b0;
  endtask

  initial begin
    meter = new();
    in_ch.valid          = 1'b0;
    in_ch.pair_index     = '0;
    in_ch.voltage_sample = '0;
    in_ch.current_sample = '0;
    in_ch.window_end     = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes under reset scales, every pair, single- and two-sample windows
    send_sample(2'd0, 16'h8000, 16'h8000, 1'b1);
    send_sample(2'd1, 16'h7FFF, 16'h8000, 1'b1);
    send_sample(2'd2, 16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(2'd2, 16'h8000, 16'h7FFF, 1'b1);
    send_sample(2'd3, 16'h0000, 16'h8000, 1'b1);
    send_sample(2'd3, 16'hFFFF, 16'h0001, 1'b1);
    send_sample(2'd0, 16'h0001, 16'h0001, 1'b0);
    send_sample(2'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(2'd0, 16'hFFFF, 16'h0001, 1'b1);
    send_sample(2'd1, 16'h0003, 16'hFFFE, 1'b1);

    // largest scales: long windows reach both active sum limits
    set_scales(24'hFFFFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 520; k++) send_sample(2'd1, 16'h8000, 16'h8000, k == 519);
    for (int k = 0; k < 520; k++) send_sample(2'd2, 16'h7FFF, 16'h8000, k == 519);
    send_sample(2'd3, 16'h8000, 16'h7FFF, 1'b1);
    random_phase(300);

    // zero scales
    set_scales('0, '0);
    send_sample(2'd0, 16'h7FFF, 16'h7FFF, 1'b1);
    random_phase(150);

    // random scales, then back to the reset values
    set_scales(pem_pkg::PScaleW'($urandom), $urandom);
    random_phase(250);
    set_scales(pem_pkg::PowerScaleRst, pem_pkg::EnergyScaleRst);
    random_phase(250);

    in_ch.valid = 1'b0;
    while (meter.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (meter.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pem_pkg.sv
rtl/core/pem_if.sv
rtl/core/pem_mul.sv
rtl/core/pem_sqrt.sv
rtl/core/pem_dp.sv
rtl/core/pem_ctrl.sv
rtl/core/power_energy_meter.sv
verif/power_energy_meter_test.sv
